FILE: hw/rtl/stt_pkg.sv
// Shared types, codes and helpers of the search transposition table.
package stt_pkg;

  // Default number of index bits of the table.
  localparam int TABLE_INDEX_BITS_DEFAULT = 10;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_PROBE      = 2'd0;
  localparam logic [1:0] OP_STORE      = 2'd1;
  localparam logic [1:0] OP_MOVE_PROBE = 2'd2;
  localparam logic [1:0] OP_CLEAR      = 2'd3;

  // Bound kinds held in an entry.
  localparam logic [1:0] BOUND_EXACT = 2'd0;
  localparam logic [1:0] BOUND_UPPER = 2'd1;
  localparam logic [1:0] BOUND_LOWER = 2'd2;

  // Depth code of an empty entry.
  localparam logic signed [7:0] DEPTH_EMPTY = -8'sd1;

  // One table entry as it is held in memory.
  typedef struct packed {
    logic [63:0]        hash;
    logic signed [15:0] score;
    logic [5:0]         source;
    logic [5:0]         target;
    logic signed [7:0]  depth;
    logic [1:0]         bound;
    logic [15:0]        age;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  // One request as accepted from the input stream.
  typedef struct packed {
    logic [1:0]         operation;
    logic [63:0]        position_hash;
    logic [6:0]         remaining_depth;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic signed [15:0] score;
    logic [5:0]         move_source;
    logic [5:0]         move_target;
  } request_t;

  // One result as delivered on the output stream.
  typedef struct packed {
    logic               hit;
    logic               cutoff;
    logic               written;
    logic signed [15:0] stored_score;
    logic [5:0]         stored_source;
    logic [5:0]         stored_target;
    logic signed [7:0]  stored_depth;
    logic [1:0]         stored_bound;
  } result_t;

  // Contents of an entry after reset or a clear.
  function automatic entry_t empty_entry();
    entry_t e;
    e        = '0;
    e.depth  = DEPTH_EMPTY;
    return e;
  endfunction

endpackage

FILE: hw/rtl/stt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/stt_eval.sv
// Compares a request with the entry read for it and forms the result and new entry.
module stt_eval (
  input  stt_pkg::request_t req,
  input  stt_pkg::entry_t   entry,
  input  logic [15:0]       current_age,
  output stt_pkg::result_t  res,
  output logic              replace,
  output stt_pkg::entry_t   new_entry
);

  logic                     hash_eq;
  logic signed [7:0]        req_depth;
  logic                     report;
  logic                     hit;
  logic                     cutoff;
  logic                     has_move;
  logic [1:0]               new_bound;

  assign hash_eq   = (entry.hash == req.position_hash);
  assign req_depth = $signed({1'b0, req.remaining_depth});
  assign has_move  = (req.move_source != 6'd0) && (req.move_target != 6'd0);

  // Bound kind of a score against the window; the upper bound test only
  // applies when the score is below beta.
  always_comb begin
    if (req.score >= req.beta) begin
      new_bound = stt_pkg::BOUND_LOWER;
    end else if (req.score <= req.alpha) begin
      new_bound = stt_pkg::BOUND_UPPER;
    end else begin
      new_bound = stt_pkg::BOUND_EXACT;
    end
  end

  // Per-operation decision.
  always_comb begin
    report  = 1'b0;
    hit     = 1'b0;
    cutoff  = 1'b0;
    replace = 1'b0;
    case (req.operation)
      stt_pkg::OP_PROBE: begin
        report = 1'b1;
        hit    = hash_eq && (entry.depth >= req_depth);
        cutoff = hit &&
                 ((entry.bound == stt_pkg::BOUND_UPPER && entry.score <= req.alpha) ||
                  (entry.bound == stt_pkg::BOUND_LOWER && entry.score >= req.beta) ||
                  (entry.bound == stt_pkg::BOUND_EXACT));
      end
      stt_pkg::OP_MOVE_PROBE: begin
        report = 1'b1;
        hit    = hash_eq;
      end
      stt_pkg::OP_STORE: begin
        replace = has_move &&
                  ((entry.depth <= req_depth) || (entry.age < current_age));
      end
      default: begin
        report = 1'b0;
      end
    endcase
  end

  // Result fields: the entry on a hit, an empty depth on a reported miss.
  always_comb begin
    res               = '0;
    res.hit           = hit;
    res.cutoff        = cutoff;
    res.written       = replace;
    if (report) begin
      if (hit) begin
        res.stored_score  = entry.score;
        res.stored_source = entry.source;
        res.stored_target = entry.target;
        res.stored_depth  = entry.depth;
        res.stored_bound  = entry.bound;
      end else begin
        res.stored_depth  = stt_pkg::DEPTH_EMPTY;
      end
    end
  end

  // Entry written back by a store that replaces.
  always_comb begin
    new_entry.hash   = req.position_hash;
    new_entry.score  = req.score;
    new_entry.source = req.move_source;
    new_entry.target = req.move_target;
    new_entry.depth  = req_depth;
    new_entry.bound  = new_bound;
    new_entry.age    = current_age;
  end

endmodule

FILE: hw/rtl/search_transposition_table.sv
// Top level of the direct-mapped search transposition table.
//
// Requests arrive as beats on the s_axis channel; the operation code is in
// s_axis_tuser and the remaining request fields in s_axis_tdata. Every
// request gives exactly one result beat on the m_axis channel, with the
// hit, cutoff and written flags in m_axis_tuser and the entry fields in
// m_axis_tdata. The current age register is written through the cfg
// channel, which is always ready.
// A probe, move probe or store reads its entry from the table memory as
// the beat is taken; the look state evaluates it, writes a replacing
// store back and loads the result into the output register. The look
// state waits while that register still holds an unsent result, and a new
// request is taken only once it is done. A clear sweeps the table one
// entry a cycle, then gives its result beat through the look state.
// After reset the same sweep runs, during which no request is taken;
// configuration writes are taken throughout.
// When the receiver stalls, the finished result waits in the output
// register; one further request is taken and held until the register
// frees, then the input waits.
module search_transposition_table #(
  parameter int TABLE_INDEX_BITS = stt_pkg::TABLE_INDEX_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration: current_age.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data,
  // Request stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: position_hash[63:0], remaining_depth[70:64], alpha[86:71],
  // beta[102:87], score[118:103], move_source[124:119],
  // move_target[130:125], zero fill[135:131].
  input  logic [135:0] s_axis_tdata,
  // tuser: operation[1:0].
  input  logic [1:0]   s_axis_tuser,
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: stored_score[15:0], stored_source[21:16], stored_target[27:22],
  // stored_depth[35:28], stored_bound[37:36], zero fill[39:38].
  output logic [39:0]  m_axis_tdata,
  // tuser: hit[0], cutoff[1], written[2].
  output logic [2:0]   m_axis_tuser
);

  localparam int DEPTH = 1 << TABLE_INDEX_BITS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOOK  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  logic [1:0]                  state;
  logic [TABLE_INDEX_BITS-1:0] clr_ptr;
  logic                        clr_report;
  logic [15:0]                 current_age;
  stt_pkg::request_t           req;
  stt_pkg::result_t            out_res;
  logic                        out_valid;

  logic                        in_accept;
  logic                        out_free;
  logic                        look_go;
  logic                        clr_last;
  stt_pkg::request_t           in_req;
  stt_pkg::entry_t             rd_entry;
  stt_pkg::entry_t             new_entry;
  stt_pkg::result_t            eval_res;
  logic                        replace;
  logic                        ram_we;
  logic [TABLE_INDEX_BITS-1:0] ram_waddr;
  stt_pkg::entry_t             ram_wdata;

  // Handshakes.
  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign look_go       = (state == ST_LOOK) && out_free;
  assign clr_last      = &clr_ptr;

  // Unpack the request beat.
  always_comb begin
    in_req.operation       = s_axis_tuser;
    in_req.position_hash   = s_axis_tdata[63:0];
    in_req.remaining_depth = s_axis_tdata[70:64];
    in_req.alpha           = s_axis_tdata[86:71];
    in_req.beta            = s_axis_tdata[102:87];
    in_req.score           = s_axis_tdata[118:103];
    in_req.move_source     = s_axis_tdata[124:119];
    in_req.move_target     = s_axis_tdata[130:125];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_age <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      current_age <= cfg_data;
    end
  end

  // Request hold register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req <= in_req;
    end
  end

  // Sequencer: read, evaluate and write back, or sweep the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_ptr    <= '0;
      clr_report <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_req.operation == stt_pkg::OP_CLEAR) begin
              state      <= ST_CLEAR;
              clr_ptr    <= '0;
              clr_report <= 1'b1;
            end else begin
              state <= ST_LOOK;
            end
          end
        end
        ST_LOOK: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (clr_last) begin
            state <= clr_report ? ST_LOOK : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Table memory write selection.
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_ptr;
      ram_wdata = stt_pkg::empty_entry();
    end else begin
      ram_we    = look_go && replace;
      ram_waddr = req.position_hash[TABLE_INDEX_BITS-1:0];
      ram_wdata = new_entry;
    end
  end

  stt_ram #(
    .WIDTH (stt_pkg::ENTRY_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (in_accept),
    .rd_addr (in_req.position_hash[TABLE_INDEX_BITS-1:0]),
    .rd_data (rd_entry)
  );

  stt_eval u_eval (
    .req         (req),
    .entry       (rd_entry),
    .current_age (current_age),
    .res         (eval_res),
    .replace     (replace),
    .new_entry   (new_entry)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (look_go) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (look_go) begin
      out_res <= eval_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = {out_res.written, out_res.cutoff, out_res.hit};
  assign m_axis_tdata  = {2'b00, out_res.stored_bound, out_res.stored_depth,
                          out_res.stored_target, out_res.stored_source,
                          out_res.stored_score};

  // The table is never written while waiting for a request.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ram_we)
    else $error("table written while idle");

  // A finished sweep always leaves the pointer at zero.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (clr_ptr == '0))
    else $error("clear pointer not at zero between requests");

  // A result flagged as written must come with a table write.
  assert property (@(posedge clk) disable iff (rst)
    (look_go && eval_res.written) |-> ram_we)
    else $error("written flag without a table write");

  // A cutoff is only reported on a hit.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
    else $error("cutoff reported without a hit");

endmodule

FILE: test/search_transposition_table_test.sv
// Self-checking testbench of the search transposition table, stream in, stream out.
module search_transposition_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int INDEX_BITS     = stt_pkg::TABLE_INDEX_BITS_DEFAULT;
  localparam int SLOTS          = 1 << INDEX_BITS;
  localparam int POOL_SIZE      = 24;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  // Directed keys; the first three share one table slot.
  localparam logic [63:0] KEY_A    = 64'h0123_4567_89AB_C0D5;
  localparam logic [63:0] KEY_B    = 64'hFEDC_BA98_7654_30D5;
  localparam logic [63:0] KEY_C    = 64'h5555_AAAA_0000_04D5;
  localparam logic [63:0] KEY_LOW  = 64'h8000_0000_0000_0123;
  localparam logic [63:0] KEY_HIGH = 64'h7FFF_FFFF_FFFF_F246;
  localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] KEY_SLOT0 = 64'hABCD_0000_0000_0000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // tdata: position_hash, remaining_depth, alpha, beta, score, move_source,
  // move_target, zero fill (lowest bit first).
  logic [135:0] s_axis_tdata = '0;
  // tuser: operation.
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // tdata: stored_score, stored_source, stored_target, stored_depth,
  // stored_bound, zero fill (lowest bit first).
  logic [39:0]  m_axis_tdata;
  // tuser: hit, cutoff, written (lowest bit first).
  logic [2:0]   m_axis_tuser;

  // Shadow copy of the table and the age register.
  stt_pkg::entry_t  shadow_table [SLOTS];
  logic [15:0]      shadow_age = '0;
  stt_pkg::result_t pending_results [$];

  logic [63:0] hash_pool [POOL_SIZE];
  logic [15:0] pool_centre [POOL_SIZE];

  int   failures = 0;
  int   quiet_cycles = 0;
  bit   sender_pauses = 1'b1;
  bit   receiver_pauses = 1'b1;
  int   holdoff_requests = 0;
  int   holdoff_served = 0;
  int   holdoff_left = 0;

  search_transposition_table DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Empties every slot of the shadow table.
  function automatic void empty_shadow_table();
    for (int i = 0; i < SLOTS; i++) begin
      shadow_table[i]       = '0;
      shadow_table[i].depth = stt_pkg::DEPTH_EMPTY;
    end
  endfunction

  // Applies one request to the shadow table and returns the result it yields.
  function automatic stt_pkg::result_t apply_to_shadow(stt_pkg::request_t req);
    stt_pkg::result_t      res;
    stt_pkg::entry_t       slot;
    logic [INDEX_BITS-1:0] idx;
    logic signed [7:0]  slot_depth;
    logic signed [15:0] slot_score;
    logic signed [15:0] req_alpha;
    logic signed [15:0] req_beta;
    logic signed [15:0] req_score;
    logic [1:0]         kind;
    logic               matched;
    res        = '0;
    idx        = req.position_hash[INDEX_BITS-1:0];
    slot       = shadow_table[idx];
    slot_depth = slot.depth;
    slot_score = slot.score;
    req_alpha  = req.alpha;
    req_beta   = req.beta;
    req_score  = req.score;
    matched    = 1'b0;
    case (req.operation)
      stt_pkg::OP_PROBE: begin
        matched = (slot.hash == req.position_hash) &&
                  (int'(slot_depth) >= int'(req.remaining_depth));
        if (matched) begin
          res.cutoff = (slot.bound == stt_pkg::BOUND_UPPER && slot_score <= req_alpha) ||
                       (slot.bound == stt_pkg::BOUND_LOWER && slot_score >= req_beta) ||
                       (slot.bound == stt_pkg::BOUND_EXACT);
        end
      end
      stt_pkg::OP_MOVE_PROBE: begin
        matched = (slot.hash == req.position_hash);
      end
      stt_pkg::OP_STORE: begin
        // A store without a move leaves the table alone.
        if (req.move_source != 0 && req.move_target != 0) begin
          if (req_score >= req_beta) begin
            kind = stt_pkg::BOUND_LOWER;
          end else if (req_score <= req_alpha) begin
            kind = stt_pkg::BOUND_UPPER;
          end else begin
            kind = stt_pkg::BOUND_EXACT;
          end
          if (int'(slot_depth) <= int'(req.remaining_depth) || slot.age < shadow_age) begin
            slot.hash   = req.position_hash;
            slot.score  = req_score;
            slot.source = req.move_source;
            slot.target = req.move_target;
            slot.depth  = {1'b0, req.remaining_depth};
            slot.bound  = kind;
            slot.age    = shadow_age;
            shadow_table[idx] = slot;
            res.written = 1'b1;
          end
        end
      end
      default: begin
        empty_shadow_table();
      end
    endcase
    // Lookups report the slot contents on a match, an empty depth otherwise.
    if (req.operation == stt_pkg::OP_PROBE || req.operation == stt_pkg::OP_MOVE_PROBE) begin
      res.hit = matched;
      if (matched) begin
        res.stored_score  = slot.score;
        res.stored_source = slot.source;
        res.stored_target = slot.target;
        res.stored_depth  = slot.depth;
        res.stored_bound  = slot.bound;
      end else begin
        res.stored_depth = stt_pkg::DEPTH_EMPTY;
      end
    end
    return res;
  endfunction

  function automatic stt_pkg::request_t build_request(logic [1:0] op, logic [63:0] key,
                                                      logic [6:0] depth,
                                                      logic signed [15:0] lo,
                                                      logic signed [15:0] hi,
                                                      logic signed [15:0] eval,
                                                      logic [5:0] src, logic [5:0] dst);
    stt_pkg::request_t req;
    req.operation       = op;
    req.position_hash   = key;
    req.remaining_depth = depth;
    req.alpha           = lo;
    req.beta            = hi;
    req.score           = eval;
    req.move_source     = src;
    req.move_target     = dst;
    return req;
  endfunction

  // Random request, mostly on pooled keys so that slots are revisited.
  function automatic stt_pkg::request_t random_request();
    stt_pkg::request_t req;
    int          roll;
    int          k;
    logic [15:0] centre;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      req.operation = stt_pkg::OP_PROBE;
    end else if (roll < 75) begin
      req.operation = stt_pkg::OP_STORE;
    end else if (roll < 99) begin
      req.operation = stt_pkg::OP_MOVE_PROBE;
    end else begin
      req.operation = stt_pkg::OP_CLEAR;
    end
    k    = $urandom_range(0, POOL_SIZE - 1);
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      req.position_hash = '0;
    end else if (roll < 18) begin
      req.position_hash = {$urandom, $urandom};
    end else begin
      req.position_hash = hash_pool[k];
    end
    if ($urandom_range(0, 99) < 70) begin
      req.remaining_depth = 7'($urandom_range(0, 15));
    end else begin
      req.remaining_depth = 7'($urandom_range(0, 127));
    end
    // Windows mostly sit near the key's typical score, sometimes anywhere.
    if ($urandom_range(0, 99) < 20) begin
      req.alpha = 16'($urandom);
      req.beta  = 16'($urandom);
      req.score = 16'($urandom);
    end else begin
      centre    = pool_centre[k] + 16'($urandom_range(0, 32)) - 16'd16;
      req.alpha = centre - 16'($urandom_range(0, 60));
      req.beta  = centre + 16'($urandom_range(0, 60));
      req.score = centre + 16'($urandom_range(0, 160)) - 16'd80;
    end
    req.move_source = ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
    req.move_target = ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
    return req;
  endfunction

  // Offers one request beat and records its expected result once taken.
  // Valid stays high afterwards so that back-to-back beats need no toggle.
  task automatic send_request(stt_pkg::request_t req);
    while (sender_pauses && $urandom_range(0, 99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.operation;
    s_axis_tdata  <= {5'b0, req.move_target, req.move_source, req.score, req.beta,
                      req.alpha, req.remaining_depth, req.position_hash};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(apply_to_shadow(req));
  endtask

  // Stops offering requests and waits for every outstanding result.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the age register once the table is idle.
  task automatic write_age(logic [15:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    shadow_age = value;
  endtask

  task automatic check_field(string name, logic signed [31:0] expected,
                             logic signed [31:0] actual);
    if (actual !== expected) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      failures++;
    end
  endtask

  // Store, probe and move probe on one slot, with aliasing keys.
  task automatic test_store_and_probe();
    send_request(build_request(stt_pkg::OP_PROBE, KEY_A, 7'd0, -16'sd50, 16'sd200, 16'sd0,
                               6'd1, 6'd1));
    send_request(build_request(stt_pkg::OP_STORE, KEY_A, 7'd5, -16'sd50, 16'sd200, 16'sd100,
                               6'd12, 6'd28));
    send_request(build_request(stt_pkg::OP_PROBE, KEY_A, 7'd5, -16'sd50, 16'sd200, 16'sd0,
                               6'd0, 6'd0));
    send_request(build_request(stt_pkg::OP_PROBE, KEY_A, 7'd6, -16'sd50, 16'sd200, 16'sd0,
                               6'd0, 6'd0));
    send_request(build_request(stt_pkg::OP_MOVE_PROBE, KEY_A, 7'd127, 16'sd0, 16'sd0, 16'sd0,
                               6'd0, 6'd0));
    // Stores without a move are dropped.
    send_request(build_request(stt_pkg::OP_STORE, KEY_A, 7'd9, -16'sd50, 16'sd200, 16'sd10,
                               6'd0, 6'd7));
    send_request(build_request(stt_pkg::OP_STORE, KEY_A, 7'd9, -16'sd50, 16'sd200, 16'sd10,
                               6'd7, 6'd0));
    // A shallower store of the same age does not replace.
    send_request(build_request(stt_pkg::OP_STORE, KEY_A, 7'd3, -16'sd50, 16'sd200, 16'sd10,
                               6'd7, 6'd9));
    send_request(build_request(stt_pkg::OP_STORE, KEY_B, 7'd5, -16'sd50, 16'sd200, 16'sd20,
                               6'd63, 6'd63));
    send_request(build_request(stt_pkg::OP_PROBE, KEY_A, 7'd0, -16'sd50, 16'sd200, 16'sd0,
                               6'd0, 6'd0));
  endtask

  // Bound classification and cutoff at the edges of the window.
  task automatic test_bounds_and_cutoff();
    send_request(build_request(stt_pkg::OP_STORE, KEY_LOW, 7'd127, -16'sd100, 16'sd300,
                               16'sd300, 6'd2, 6'd3));
    send_request(build_request(stt_pkg::OP_PROBE, KEY_LOW, 7'd127, -16'sd100, 16'sd300,
                               16'sd0, 6'd0, 6'd0));
    send_request(build_request(stt_pkg::OP_PROBE, KEY_LOW, 7'd4, -16'sd100, 16'sd301,
                               16'sd0, 6'd0, 6'd0));
    send_request(build_request(stt_pkg::OP_STORE, KEY_HIGH, 7'd8, -16'sd200, 16'sd100,
                               -16'sd200, 6'd4, 6'd5));
    send_request(build_request(stt_pkg::OP_PROBE, KEY_HIGH, 7'd8, -16'sd200, 16'sd100,
                               16'sd0, 6'd0, 6'd0));
    send_request(build_request(stt_pkg::OP_PROBE, KEY_HIGH, 7'd8, -16'sd201, 16'sd100,
                               16'sd0, 6'd0, 6'd0));
    // Inverted window is taken as it stands.
    send_request(build_request(stt_pkg::OP_STORE, KEY_ONES, 7'd127, 16'sd500, -16'sd500,
                               16'sd0, 6'd63, 6'd1));
    send_request(build_request(stt_pkg::OP_PROBE, KEY_ONES, 7'd127, -16'sd32768, 16'sd32767,
                               16'sd0, 6'd0, 6'd0));
    send_request(build_request(stt_pkg::OP_STORE, KEY_ONES, 7'd127, -16'sd32768, 16'sd32767,
                               -16'sd32768, 6'd63, 6'd63));
    send_request(build_request(stt_pkg::OP_PROBE, KEY_ONES, 7'd127, -16'sd32768, 16'sd32767,
                               16'sd32767, 6'd0, 6'd0));
  endtask

  // An entry whose age is above the current age is not replaced by a shallower store after the age wraps to zero.
  task automatic test_age_replacement();
    write_age(16'hFFFF);
    send_request(build_request(stt_pkg::OP_STORE, KEY_C, 7'd1, -16'sd10, 16'sd10, 16'sd32767,
                               6'd33, 6'd44));
    write_age(16'h0000);
    send_request(build_request(stt_pkg::OP_STORE, KEY_A, 7'd0, -16'sd10, 16'sd10, 16'sd0,
                               6'd5, 6'd6));
    send_request(build_request(stt_pkg::OP_PROBE, KEY_C, 7'd1, -16'sd10, 16'sd10, 16'sd0,
                               6'd0, 6'd0));
  endtask

  // Empty entries under a zero key, and clearing the whole table.
  task automatic test_empty_and_clear();
    send_request(build_request(stt_pkg::OP_MOVE_PROBE, 64'd0, 7'd0, 16'sd0, 16'sd0, 16'sd0,
                               6'd0, 6'd0));
    send_request(build_request(stt_pkg::OP_PROBE, 64'd0, 7'd0, 16'sd0, 16'sd0, 16'sd0,
                               6'd0, 6'd0));
    send_request(build_request(stt_pkg::OP_CLEAR, KEY_A, 7'd0, 16'sd0, 16'sd0, 16'sd0,
                               6'd0, 6'd0));
    send_request(build_request(stt_pkg::OP_PROBE, KEY_C, 7'd0, 16'sd0, 16'sd0, 16'sd0,
                               6'd0, 6'd0));
    send_request(build_request(stt_pkg::OP_STORE, KEY_SLOT0, 7'd2, 16'sd0, 16'sd0, 16'sd0,
                               6'd8, 6'd9));
    send_request(build_request(stt_pkg::OP_MOVE_PROBE, 64'd0, 7'd0, 16'sd0, 16'sd0, 16'sd0,
                               6'd0, 6'd0));
  endtask

  // Long random run in phases, each with its own age setting.
  task automatic test_random_traffic();
    int slot_pick;
    // Three keys per slot on eight slots, including the first and last.
    for (int i = 0; i < POOL_SIZE; i++) begin
      slot_pick      = i % 8;
      hash_pool[i]   = {$urandom, $urandom};
      hash_pool[i][INDEX_BITS-1:0] = (slot_pick == 0) ? '0 :
                                     (slot_pick == 7) ? '1 : INDEX_BITS'(slot_pick * 101);
      pool_centre[i] = 16'($urandom);
    end
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_age(16'd1);
        3: write_age(16'hFFFF);
        5: write_age(16'd0);
        default: write_age(16'($urandom_range(0, 65535)));
      endcase
      // Phases four and five run with neither side idling.
      sender_pauses    = (phase != 4 && phase != 5);
      receiver_pauses <= (phase != 4 && phase != 5);
      repeat (250) send_request(random_request());
    end
    sender_pauses    = 1'b1;
    receiver_pauses <= 1'b1;
  endtask

  // The receiver holds off while requests keep coming, filling the block.
  task automatic test_backpressure();
    drain_results();
    holdoff_requests <= holdoff_requests + 1;
    sender_pauses = 1'b0;
    repeat (40) send_request(random_request());
    sender_pauses = 1'b1;
  endtask

  // Result receiver with random stalls and an occasional long hold-off.
  always @(posedge clk) begin
    if (holdoff_requests != holdoff_served) begin
      holdoff_served <= holdoff_requests;
      holdoff_left   <= HOLDOFF_CYCLES;
      m_axis_tready  <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left  <= holdoff_left - 1;
      m_axis_tready <= 1'b0;
    end else if (receiver_pauses) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 27);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compares every result beat with the oldest expectation.
  always @(posedge clk) begin
    stt_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat arrived with no request outstanding");
        failures++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", want.hit, m_axis_tuser[0]);
        check_field("cutoff", want.cutoff, m_axis_tuser[1]);
        check_field("written", want.written, m_axis_tuser[2]);
        check_field("stored_score", $signed(want.stored_score), $signed(m_axis_tdata[15:0]));
        check_field("stored_source", want.stored_source, m_axis_tdata[21:16]);
        check_field("stored_target", want.stored_target, m_axis_tdata[27:22]);
        check_field("stored_depth", $signed(want.stored_depth), $signed(m_axis_tdata[35:28]));
        check_field("stored_bound", want.stored_bound, m_axis_tdata[37:36]);
      end
    end
  end

  // Ends the run if no beat of any kind moves for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    empty_shadow_table();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_age(16'd0);
    test_store_and_probe();
    test_bounds_and_cutoff();
    test_age_replacement();
    test_empty_and_clear();
    test_random_traffic();
    test_backpressure();
    drain_results();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
